// File: rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter pipeline.
package rhc_pkg;

  // Component width; red, green, blue and alpha all use it.
  localparam int COMPONENT_BITS = 16;
  localparam int HUE_BITS       = 15;
  localparam int SAT_BITS       = 16;

  // One divider step per pipeline stage; both dividers produce SAT_BITS quotient bits.
  localparam int DIV_STEPS = SAT_BITS;

  // 60 degrees in hue units (degrees times 64) and the full circle.
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL   = 23040;

  // 3840 = 2^12 - 2^8, so the scaled difference needs 12 extra bits.
  localparam int SECTOR_HI_SHIFT = 12;
  localparam int SECTOR_LO_SHIFT = 8;
  localparam int PROD_BITS       = COMPONENT_BITS + SECTOR_HI_SHIFT;

  typedef logic [COMPONENT_BITS-1:0] comp_t;
  typedef logic [PROD_BITS-1:0]      prod_t;

  // Input beat.
  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
    comp_t alpha;
  } pixel_t;

  // Output beat.
  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    comp_t               brightness;
    comp_t               alpha_out;
  } hsv_t;

  // Which component is the largest, with ties resolved red, green, blue.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // One lane of the restoring divider: partial remainder, dividend/quotient
  // shift register and divisor.
  typedef struct packed {
    comp_t                rem;
    logic [DIV_STEPS-1:0] dq;
    comp_t                divisor;
  } div_lane_t;

  // Side information that rides along with the dividers.
  typedef struct packed {
    sector_t sector;
    logic    neg;
    logic    grey;
    logic    black;
    logic    sat_full;
    comp_t   brightness;
    comp_t   alpha;
  } div_ctx_t;

  typedef struct packed {
    div_lane_t hue_lane;
    div_lane_t sat_lane;
    div_ctx_t  ctx;
  } div_beat_t;

endpackage

// File: rtl/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter: front end, divider chain, finish and output buffer.
//
//   Channel  Valid        Stall        Beat     Direction
//   -------  -----------  -----------  -------  ---------
//   pixel    pixel_valid  pixel_stall  pixel    in
//   hsv      hsv_valid    hsv_stall    hsv      out
//
// One pixel is accepted per clock while pixel_stall is low; its result passes through three
// front-end stages, sixteen divider steps, one finish stage and the output register (the two
// restoring dividers set the depth).
// Reset clears only the valid bits; the datapath has no state between pixels.
// A stalled output fills a one-beat skid entry, and pixel_stall follows that
// entry, so the whole pipeline freezes for as long as it is full.
module rgb_to_hsv_converter_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_stall,
  input  rhc_pkg::pixel_t pixel,
  output logic            hsv_valid,
  input  logic            hsv_stall,
  output rhc_pkg::hsv_t   hsv
);
  import rhc_pkg::*;

  logic      en;
  logic      hold;
  logic      div_valid [DIV_STEPS+1];
  div_beat_t div_beat  [DIV_STEPS+1];
  logic      fin_valid;
  hsv_t      fin_hsv;

  // The pipeline advances whenever the skid entry is empty.
  assign en          = !hold;
  assign pixel_stall = hold;

  // Max/min, difference and divider setup.
  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid),
    .in_pixel  (pixel),
    .out_valid (div_valid[0]),
    .out_beat  (div_beat[0])
  );

  // Divider chain, one quotient bit per stage for both dividers.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rhc_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_valid[i]),
      .in_beat   (div_beat[i]),
      .out_valid (div_valid[i+1]),
      .out_beat  (div_beat[i+1])
    );
  end

  // Hue fix-up and saturation limits.
  rhc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid[DIV_STEPS]),
    .in_beat   (div_beat[DIV_STEPS]),
    .out_valid (fin_valid),
    .out_hsv   (fin_hsv)
  );

  // Output register and skid entry.
  rhc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .in_hsv    (fin_hsv),
    .hold      (hold),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv)
  );

`ifndef SYNTH
  // A full skid entry always sits behind an occupied output register.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    hold |-> hsv_valid)
    else $error("skid entry full while output register is empty");

  // While the skid entry is full the pipeline must not move.
  a_frozen_on_hold: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(fin_valid) && $stable(div_valid[DIV_STEPS]))
    else $error("pipeline moved while held");

  // Hue always lands inside one full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue < HUE_BITS'(HUE_FULL))
    else $error("hue out of range");

  // A black pixel has neither hue nor saturation.
  a_black_pixel: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (hsv.brightness == '0) |-> (hsv.saturation == '0) && (hsv.hue == '0))
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

// File: rtl/rhc_front.sv
// Front end: max/min search, range and difference, and divider setup in three stages.
module rhc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rhc_pkg::pixel_t    in_pixel,
  output logic               out_valid,
  output rhc_pkg::div_beat_t out_beat
);
  import rhc_pkg::*;

  // Stage A registers.
  logic    a_valid;
  pixel_t  a_pixel;
  comp_t   a_max;
  comp_t   a_min;
  sector_t a_sector;

  // Stage B registers.
  logic    b_valid;
  comp_t   b_range;
  comp_t   b_absdiff;
  logic    b_neg;
  sector_t b_sector;
  comp_t   b_max;
  comp_t   b_alpha;
  logic    b_grey;
  logic    b_black;
  logic    b_sat_full;

  // Stage A logic.
  logic    g_gt_r;
  logic    b_gt_r;
  logic    b_gt_g;
  sector_t sector_next;
  comp_t   max_next;
  comp_t   min_next;

  // Stage B logic.
  comp_t op_x;
  comp_t op_y;

  // Stage C logic.
  prod_t     scaled;
  div_beat_t beat_next;

  // Largest component with red winning ties, then green.
  always_comb begin
    g_gt_r = in_pixel.green > in_pixel.red;
    b_gt_r = in_pixel.blue > in_pixel.red;
    b_gt_g = in_pixel.blue > in_pixel.green;
    if (!g_gt_r && !b_gt_r) begin
      sector_next = SEC_RED;
      max_next    = in_pixel.red;
    end else if (g_gt_r && !b_gt_g) begin
      sector_next = SEC_GREEN;
      max_next    = in_pixel.green;
    end else begin
      sector_next = SEC_BLUE;
      max_next    = in_pixel.blue;
    end
    // With green not above red the minimum is the smaller of green and blue,
    // otherwise it is the smaller of red and blue.
    if (!g_gt_r) begin
      min_next = b_gt_g ? in_pixel.green : in_pixel.blue;
    end else begin
      min_next = b_gt_r ? in_pixel.red : in_pixel.blue;
    end
  end

  // Operands of the hue difference depend on the winning component.
  always_comb begin
    case (a_sector)
      SEC_RED: begin
        op_x = a_pixel.green;
        op_y = a_pixel.blue;
      end
      SEC_GREEN: begin
        op_x = a_pixel.blue;
        op_y = a_pixel.red;
      end
      SEC_BLUE: begin
        op_x = a_pixel.red;
        op_y = a_pixel.green;
      end
      default: begin
        op_x = a_pixel.green;
        op_y = a_pixel.blue;
      end
    endcase
  end

  // Scale the magnitude by one sector with shifts and set up both dividers.
  // The hue quotient stays below 2^DIV_STEPS, so the dividend bits above
  // DIV_STEPS already form a remainder smaller than the divisor.
  always_comb begin
    scaled = {b_absdiff, {SECTOR_HI_SHIFT{1'b0}}}
           - {{(SECTOR_HI_SHIFT - SECTOR_LO_SHIFT){1'b0}}, b_absdiff,
              {SECTOR_LO_SHIFT{1'b0}}};
    beat_next.hue_lane.rem     = {{(COMPONENT_BITS - PROD_BITS + DIV_STEPS){1'b0}},
                                  scaled[PROD_BITS-1:DIV_STEPS]};
    beat_next.hue_lane.dq      = scaled[DIV_STEPS-1:0];
    beat_next.hue_lane.divisor = b_range;
    beat_next.sat_lane.rem     = b_range;
    beat_next.sat_lane.dq      = '0;
    beat_next.sat_lane.divisor = b_max;
    beat_next.ctx.sector       = b_sector;
    beat_next.ctx.neg          = b_neg;
    beat_next.ctx.grey         = b_grey;
    beat_next.ctx.black        = b_black;
    beat_next.ctx.sat_full     = b_sat_full;
    beat_next.ctx.brightness   = b_max;
    beat_next.ctx.alpha        = b_alpha;
  end

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // Payload registers for the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      a_pixel    <= in_pixel;
      a_max      <= max_next;
      a_min      <= min_next;
      a_sector   <= sector_next;
      b_range    <= a_max - a_min;
      b_neg      <= op_x < op_y;
      b_absdiff  <= (op_x < op_y) ? (op_y - op_x) : (op_x - op_y);
      b_sector   <= a_sector;
      b_max      <= a_max;
      b_alpha    <= a_pixel.alpha;
      b_grey     <= a_max == a_min;
      b_black    <= a_max == '0;
      b_sat_full <= (a_min == '0) && (a_max != '0);
      out_beat   <= beat_next;
    end
  end

endmodule

// File: rtl/rhc_div_step.sv
// One restoring division step for the hue and saturation dividers, registered.
module rhc_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rhc_pkg::div_beat_t in_beat,
  output logic               out_valid,
  output rhc_pkg::div_beat_t out_beat
);
  import rhc_pkg::*;

  div_beat_t beat_next;

  // Shift one dividend bit into the remainder, subtract the divisor when it fits.
  function automatic div_lane_t lane_step(input div_lane_t lane);
    logic [COMPONENT_BITS:0] rem_shift;
    logic [COMPONENT_BITS:0] rem_sub;
    logic                    fits;
    div_lane_t               res;
    rem_shift   = {lane.rem, lane.dq[DIV_STEPS-1]};
    rem_sub     = rem_shift - {1'b0, lane.divisor};
    fits        = rem_shift >= {1'b0, lane.divisor};
    res.rem     = fits ? rem_sub[COMPONENT_BITS-1:0] : rem_shift[COMPONENT_BITS-1:0];
    res.dq      = {lane.dq[DIV_STEPS-2:0], fits};
    res.divisor = lane.divisor;
    return res;
  endfunction

  always_comb begin
    beat_next.hue_lane = lane_step(in_beat.hue_lane);
    beat_next.sat_lane = lane_step(in_beat.sat_lane);
    beat_next.ctx      = in_beat.ctx;
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      out_beat <= beat_next;
    end
  end

endmodule

// File: rtl/rhc_finish.sv
// Final stage: floor correction, sector offset and wrap for hue; saturation limits.
module rhc_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rhc_pkg::div_beat_t in_beat,
  output logic               out_valid,
  output rhc_pkg::hsv_t      out_hsv
);
  import rhc_pkg::*;

  localparam int ACC_BITS = DIV_STEPS + 2;
  localparam logic signed [ACC_BITS-1:0] FULL_S = ACC_BITS'(HUE_FULL);

  logic signed [ACC_BITS-1:0] q_ext;
  logic signed [ACC_BITS-1:0] q_term;
  logic signed [ACC_BITS-1:0] offset;
  logic signed [ACC_BITS-1:0] carry;
  logic signed [ACC_BITS-1:0] h_sum;
  logic signed [ACC_BITS-1:0] h_wrap;
  logic                       rem_nz;
  hsv_t                       hsv_next;

  // A negative quotient floors toward minus infinity: -(q + (rem != 0)),
  // which is ~q + 1 - (rem != 0), folded into one three-input add.
  always_comb begin
    rem_nz = in_beat.hue_lane.rem != '0;
    q_ext  = $signed({2'b00, in_beat.hue_lane.dq});
    q_term = in_beat.ctx.neg ? ~q_ext : q_ext;
    carry  = $signed({{(ACC_BITS-1){1'b0}}, in_beat.ctx.neg & ~rem_nz});
    case (in_beat.ctx.sector)
      SEC_RED:   offset = '0;
      SEC_GREEN: offset = ACC_BITS'(2 * HUE_SECTOR);
      SEC_BLUE:  offset = ACC_BITS'(4 * HUE_SECTOR);
      default:   offset = '0;
    endcase
    h_sum = offset + q_term + carry;
    if (h_sum < 0) begin
      h_wrap = h_sum + FULL_S;
    end else if (h_sum >= FULL_S) begin
      h_wrap = h_sum - FULL_S;
    end else begin
      h_wrap = h_sum;
    end
  end

  // Assemble the result beat with the grey, black and full-saturation cases.
  always_comb begin
    hsv_next.hue = in_beat.ctx.grey ? '0 : h_wrap[HUE_BITS-1:0];
    if (in_beat.ctx.black) begin
      hsv_next.saturation = '0;
    end else if (in_beat.ctx.sat_full) begin
      hsv_next.saturation = '1;
    end else begin
      hsv_next.saturation = in_beat.sat_lane.dq[SAT_BITS-1:0];
    end
    hsv_next.brightness = in_beat.ctx.brightness;
    hsv_next.alpha_out  = in_beat.ctx.alpha;
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      out_hsv <= hsv_next;
    end
  end

endmodule

// File: rtl/rhc_out_buf.sv
// Output register with a one-beat skid entry; its fill state freezes the pipeline.
module rhc_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rhc_pkg::hsv_t in_hsv,
  output logic          hold,
  output logic          hsv_valid,
  input  logic          hsv_stall,
  output rhc_pkg::hsv_t hsv
);
  import rhc_pkg::*;

  logic skid_valid;
  hsv_t skid;
  logic room;

  // The output register can take a beat when it is empty or being taken.
  assign room = !hsv_valid || !hsv_stall;
  assign hold = skid_valid;

  // Control: the skid entry drains first; a new beat lands in the skid entry
  // only when the output register is occupied and stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (room) begin
        hsv_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (room) begin
        hsv_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (!hsv_stall) begin
      hsv_valid <= 1'b0;
    end
  end

  // Payload moves along the same paths.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (room) begin
        hsv <= skid;
      end
    end else if (in_valid) begin
      if (room) begin
        hsv <= in_hsv;
      end else begin
        skid <= in_hsv;
      end
    end
  end

endmodule

// File: test/rhc_hsv_checker.sv
// Checker that predicts each HSV beat from the accepted pixel and compares it with the core.
module rhc_hsv_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  input  logic            pixel_stall,
  input  rhc_pkg::pixel_t pixel,
  input  logic            hsv_valid,
  input  logic            hsv_stall,
  input  rhc_pkg::hsv_t   hsv,
  output int              failures,
  output int              pending,
  output int              checked
);
  import rhc_pkg::*;

  // HSV beats owed by the core, oldest first.
  hsv_t hsv_due_q[$];

  // Computes the HSV beat that a pixel must produce.
  function automatic hsv_t hsv_of_pixel(input pixel_t p);
    longint  r, g, b, mx, mn, span, diff, offset, scaled, quot, hue_deg, sat;
    sector_t sector;
    hsv_t    res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;

    // The largest component picks the sector; ties go to red, then green.
    if (mx == r) sector = SEC_RED;
    else if (mx == g) sector = SEC_GREEN;
    else sector = SEC_BLUE;
    case (sector)
      SEC_RED: begin
        diff = g - b;
        offset = 0;
      end
      SEC_GREEN: begin
        diff = b - r;
        offset = 2 * HUE_SECTOR;
      end
      default: begin
        diff = r - g;
        offset = 4 * HUE_SECTOR;
      end
    endcase

    // Hue is floored toward minus infinity before the offset, then wrapped.
    hue_deg = 0;
    if (span != 0) begin
      scaled = diff * HUE_SECTOR;
      if (scaled >= 0) quot = scaled / span;
      else quot = -((-scaled + span - 1) / span);
      hue_deg = quot + offset;
      if (hue_deg < 0) hue_deg += HUE_FULL;
      if (hue_deg >= HUE_FULL) hue_deg -= HUE_FULL;
    end

    // Saturation clips at the top since one itself does not fit in Q0.16.
    sat = 0;
    if (mx != 0) begin
      sat = (span << 16) / mx;
      if (sat > 65535) sat = 65535;
    end

    res.hue        = hue_deg[HUE_BITS-1:0];
    res.saturation = sat[SAT_BITS-1:0];
    res.brightness = mx[COMPONENT_BITS-1:0];
    res.alpha_out  = p.alpha;
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    failures++;
  endtask

  // Queue a prediction on every accepted pixel and check every accepted result.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (hsv_valid && !hsv_stall) begin
        if (hsv_due_q.size() == 0) begin
          $display("%0t: HSV beat with nothing expected: hue %0d sat %0d value %0d alpha %0d",
                   $time, hsv.hue, hsv.saturation, hsv.brightness, hsv.alpha_out);
          failures++;
        end else begin
          want = hsv_due_q.pop_front();
          checked++;
          if (hsv.hue !== want.hue) flag_field("hue", 16'(want.hue), 16'(hsv.hue));
          if (hsv.saturation !== want.saturation)
            flag_field("saturation", want.saturation, hsv.saturation);
          if (hsv.brightness !== want.brightness)
            flag_field("brightness", want.brightness, hsv.brightness);
          if (hsv.alpha_out !== want.alpha_out)
            flag_field("alpha_out", want.alpha_out, hsv.alpha_out);
        end
      end
      if (pixel_valid && !pixel_stall) hsv_due_q.push_back(hsv_of_pixel(pixel));
    end
    pending <= hsv_due_q.size();
  end

endmodule

// File: test/testbench.sv
// Top of the RGB to HSV core testbench: clock, reset, pixel stimulus, output stalls and verdict.
module testbench;
  import rhc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PIXELS = 850;
  localparam int RANDOM_BLOCKS = 10;
  localparam int DRAIN_CYCLES  = 40;

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel       = '0;
  logic   hsv_valid;
  logic   hsv_stall   = 1'b0;
  hsv_t   hsv;

  int          failures;
  int          pending;
  int          checked;
  int          pixels_sent;
  int          cycle_count;
  int unsigned stall_run;
  logic        stall_on = 1'b1;
  bit          idle_on  = 1'b1;

  rgb_to_hsv_converter_core dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
  );

  rhc_hsv_checker hsv_check (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv),
    .failures    (failures),
    .pending     (pending),
    .checked     (checked)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic pixel_t pixel_of(input comp_t r, input comp_t g, input comp_t b,
                                      input comp_t a);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  // Random pixel, biased toward greys, ties, tiny values and full-scale components.
  function automatic pixel_t random_pixel();
    int unsigned kind;
    pixel_t      p;
    p = pixel_t'({$urandom, $urandom});
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: begin
        case ($urandom_range(0, 2))
          0: p.green = p.red;
          1: p.blue = p.green;
          default: p.blue = p.red;
        endcase
      end
      2: begin
        p.red   = comp_t'($urandom_range(0, 15));
        p.green = comp_t'($urandom_range(0, 15));
        p.blue  = comp_t'($urandom_range(0, 15));
      end
      3: begin
        case ($urandom_range(0, 2))
          0: p.red = '1;
          1: p.green = '1;
          default: p.blue = '1;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  // Presents one pixel beat, holds it until accepted, then may idle for a while.
  task automatic send_pixel(input pixel_t beat);
    int unsigned gap;
    pixel       <= beat;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted result has come out.
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Output stalls of random length; no new stall starts while stall_on is low.
  always @(posedge clk) begin
    int unsigned hold;
    if (stall_run != 0) begin
      hsv_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (stall_on && !rst) begin
      hold = pick_gap();
      hsv_stall <= (hold != 0);
      stall_run <= (hold != 0) ? hold - 1 : 0;
    end else begin
      hsv_stall <= 1'b0;
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("rgb_to_hsv_converter_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned blk;
    int unsigned n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: black, white, pure primaries, every tie and the hue wrap.
    send_pixel(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pixel_of(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_pixel(pixel_of(16'hffff, 16'h0000, 16'h0000, 16'h1234));
    send_pixel(pixel_of(16'h0000, 16'hffff, 16'h0000, 16'haaaa));
    send_pixel(pixel_of(16'h0000, 16'h0000, 16'hffff, 16'h5555));
    send_pixel(pixel_of(16'h0001, 16'h0000, 16'h0000, 16'haaaa));
    send_pixel(pixel_of(16'h0000, 16'h0000, 16'h0001, 16'h5555));
    send_pixel(pixel_of(16'h0001, 16'h0001, 16'h0000, 16'h0001));
    send_pixel(pixel_of(16'h0000, 16'h0005, 16'h0005, 16'h8000));
    send_pixel(pixel_of(16'h0007, 16'h0000, 16'h0007, 16'h7fff));
    send_pixel(pixel_of(16'hffff, 16'h0000, 16'h0001, 16'hffff));
    send_pixel(pixel_of(16'hffff, 16'h0001, 16'h0000, 16'h0000));
    send_pixel(pixel_of(16'h0000, 16'hffff, 16'hfffe, 16'hf0f0));
    send_pixel(pixel_of(16'hfffe, 16'h0000, 16'hffff, 16'h0f0f));
    send_pixel(pixel_of(16'h8000, 16'h8000, 16'h8000, 16'h4321));
    send_pixel(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'hffff));
    send_pixel(pixel_of(16'h5555, 16'haaaa, 16'hffff, 16'h5555));
    send_pixel(pixel_of(16'hffff, 16'hfffe, 16'hffff, 16'haaaa));
    wait_drained();

    // Random part in blocks; every fourth block runs with both sides flat out.
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      idle_on = (blk % 4 != 2);
      stall_on <= (blk % 4 != 2);
      if (blk == 6) wait_drained();
      for (n = 0; n < RANDOM_PIXELS / RANDOM_BLOCKS; n++) send_pixel(random_pixel());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels: directed corners, greys, ties, tiny and full-scale values,",
             pixels_sent);
    $display("and random colors under random gaps and stalls; %0d HSV beats compared.",
             checked);
    if (pending != 0) $display("%0d expected HSV beats never arrived", pending);
    if (failures == 0 && pending == 0) begin
      $display("rgb_to_hsv_converter_core verification clean");
    end else begin
      $display("rgb_to_hsv_converter_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div_step.sv
rtl/rhc_finish.sv
rtl/rhc_out_buf.sv
rtl/rgb_to_hsv_converter_core.sv
test/rhc_hsv_checker.sv
test/testbench.sv
